// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL of the skip list store.
// Depends on nothing; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SKL_ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("skl: invariant broken");
`define SKL_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("skl: implication broken");
`else
`define SKL_ASSERT_ALWAYS(lbl, ck, rn, cond)
`define SKL_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hdl/skl_pkg.sv -----
// Shared constants, codes and control structs of the skip list store.
// Depends on nothing; every module and interface of the block imports it.
package skl_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int MAX_LEVELS_DEF = 16;
    localparam int COUNT_W_DEF    = 9;
    localparam int KEY_W          = 32;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int HEIGHT_BIT     = 16;

    localparam logic [KEY_W-1:0] LCG_MUL   = 32'd1664525;
    localparam logic [KEY_W-1:0] LCG_INC   = 32'd1013904223;
    localparam logic [KEY_W-1:0] SEED_INIT = 32'hdeadbeef;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WLINK,
        ST_WNODE,
        ST_WKEY,
        ST_DECIDE,
        ST_HEIGHT,
        ST_ALLOC,
        ST_LINK_SUCC,
        ST_LINK_PRED,
        ST_UNLINK_RD,
        ST_UNLINK_WR,
        ST_LOWER,
        ST_FINISH
    } fsm_state_t;

    // Commands broadcast along the row of level cells
    typedef struct packed {
        logic start;
        logic cap;
        logic link_succ;
        logic link_pred;
        logic unlink;
    } cell_cmd_t;

    // Commands to the node store
    typedef struct packed {
        logic key_we;
        logic val_we;
        logic pop;
        logic push;
    } store_ctl_t;

endpackage

// ----- hdl/skl_ifs.sv -----
// Request and response channel interfaces of the skip list store.
// Depends on skl_pkg for field widths.
interface skl_req_if;
    import skl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [KEY_W-1:0]  key;
    logic signed [KEY_W-1:0]  value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface skl_rsp_if #(
    parameter int COUNT_W = skl_pkg::COUNT_W_DEF
);
    import skl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic signed [KEY_W-1:0]  read_value;
    logic [COUNT_W-1:0]       entry_count;

    modport source (output valid, output status, output found, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found, input read_value,
                    input entry_count, output ready);
endinterface

// ----- hdl/skl_level_cell.sv -----
// One level of the skip list: header link, node links, walk token and update pointer.
// Depends on skl_pkg; instantiated in a row by the top level.
module skl_level_cell #(
    parameter int NODE_COUNT = skl_pkg::NODE_COUNT_DEF,
    parameter int LEVEL      = 0,
    parameter int LINK_W     = 9,
    parameter int NODE_W     = 8,
    parameter int LVL_W      = 5,
    parameter int LIDX_W     = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  skl_pkg::cell_cmd_t  cmd,
    input  logic [LIDX_W-1:0]   start_lvl,
    input  logic                tok_above,
    input  logic [LINK_W-1:0]   cur,
    input  logic [LINK_W-1:0]   nx,
    input  logic [NODE_W-1:0]   rd_addr,
    input  logic [NODE_W-1:0]   node,
    input  logic [LVL_W-1:0]    height,
    output logic                tok,
    output logic [LINK_W-1:0]   head_link,
    output logic [LINK_W-1:0]   rd_link
);
    import skl_pkg::*;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODE_COUNT);

    logic [LINK_W-1:0] link_mem [NODE_COUNT];
    logic [LINK_W-1:0] rd_reg;
    logic              tok_reg, tok_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] upd_reg, upd_next;
    logic [LINK_W-1:0] succ_reg, succ_next;
    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic [LINK_W-1:0] node_ext;
    logic              in_level;
    logic              upd_is_head;

    assign node_ext    = LINK_W'(node);
    assign in_level    = (height > LVL_W'(LEVEL));
    assign upd_is_head = (upd_reg == LINK_NULL);

    // Token handover and pointer capture
    always_comb
    begin
        tok_next  = tok_reg;
        upd_next  = upd_reg;
        succ_next = succ_reg;
        if (cmd.start)
        begin
            tok_next  = (start_lvl == LIDX_W'(LEVEL));
            upd_next  = LINK_NULL;
            succ_next = head_reg;
        end
        else if (cmd.cap)
        begin
            tok_next = tok_above;
            if (tok_reg)
            begin
                upd_next  = cur;
                succ_next = nx;
            end
        end
    end

    // Link writes: new node's own link, predecessor link, or unlink bypass
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = node;
        mem_wdata = succ_reg;
        head_next = head_reg;
        if (cmd.link_succ && in_level)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.link_pred && in_level)
        begin
            if (upd_is_head)
            begin
                head_next = node_ext;
            end
            else
            begin
                mem_we    = 1'b1;
                mem_waddr = upd_reg[NODE_W-1:0];
                mem_wdata = node_ext;
            end
        end
        else if (cmd.unlink && (succ_reg == node_ext))
        begin
            if (upd_is_head)
            begin
                head_next = rd_reg;
            end
            else
            begin
                mem_we    = 1'b1;
                mem_waddr = upd_reg[NODE_W-1:0];
                mem_wdata = rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= 1'b0;
            head_reg <= LINK_NULL;
        end
        else
        begin
            tok_reg  <= tok_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_reg  <= upd_next;
        succ_reg <= succ_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= link_mem[rd_addr];
    end

    assign tok       = tok_reg;
    assign head_link = head_reg;
    assign rd_link   = rd_reg;

endmodule

// ----- hdl/skl_node_store.sv -----
// Node keys, node values and the free node stack of the skip list store.
// Depends on skl_pkg for the control struct.
module skl_node_store #(
    parameter int NODE_COUNT = skl_pkg::NODE_COUNT_DEF,
    parameter int NODE_W     = 8,
    parameter int CNT_W      = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  skl_pkg::store_ctl_t     ctl,
    input  logic [NODE_W-1:0]       raddr,
    input  logic [NODE_W-1:0]       waddr,
    input  logic [skl_pkg::KEY_W-1:0] wkey,
    input  logic [skl_pkg::KEY_W-1:0] wval,
    input  logic [NODE_W-1:0]       push_node,
    output logic [skl_pkg::KEY_W-1:0] key_rd,
    output logic [skl_pkg::KEY_W-1:0] val_rd,
    output logic [NODE_W-1:0]       alloc_node,
    output logic [CNT_W-1:0]        free_count
);
    import skl_pkg::*;

    logic [KEY_W-1:0]  key_mem  [NODE_COUNT];
    logic [KEY_W-1:0]  val_mem  [NODE_COUNT];
    logic [NODE_W-1:0] free_mem [NODE_COUNT];
    logic [KEY_W-1:0]  key_rd_reg;
    logic [KEY_W-1:0]  val_rd_reg;
    logic [NODE_W-1:0] free_rd_reg;
    logic [CNT_W-1:0]  fc_reg, fc_next;
    logic [CNT_W-1:0]  low_reg, low_next;
    logic [CNT_W-1:0]  top_idx;
    logic              push_ok;

    // Stack slots below the low-water mark were never written and stand for their own index
    assign top_idx    = fc_reg - CNT_W'(1);
    assign alloc_node = (top_idx < low_reg) ? top_idx[NODE_W-1:0] : free_rd_reg;
    assign push_ok    = ctl.push && (fc_reg < CNT_W'(NODE_COUNT));

    always_comb
    begin
        fc_next  = fc_reg;
        low_next = low_reg;
        if (ctl.pop)
        begin
            fc_next = top_idx;
            if (top_idx < low_reg)
            begin
                low_next = top_idx;
            end
        end
        else if (push_ok)
        begin
            fc_next = fc_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= CNT_W'(NODE_COUNT);
            low_reg <= CNT_W'(NODE_COUNT);
        end
        else
        begin
            fc_reg  <= fc_next;
            low_reg <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[waddr] <= wkey;
        end
        if (ctl.val_we)
        begin
            val_mem[waddr] <= wval;
        end
        key_rd_reg <= key_mem[raddr];
        val_rd_reg <= val_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            free_mem[fc_reg[NODE_W-1:0]] <= push_node;
        end
        free_rd_reg <= free_mem[top_idx[NODE_W-1:0]];
    end

    assign key_rd     = key_rd_reg;
    assign val_rd     = val_rd_reg;
    assign free_count = fc_reg;

endmodule

// ----- hdl/skip_list_key_value_store_core.sv -----
// Sorted key-value store held as a skip list over a fixed pool of NODE_COUNT nodes with up
// to MAX_LEVELS link levels. A request transaction carries func (insert or update, search,
// delete), a signed key and a value; each request yields exactly one response transaction
// with status, found, read_value and the entry count after the request. Keys are ordered
// as signed numbers. Requests are worked one at a time. The links of each level live in a
// level cell of their own; the cells form a row, and a walk token enters at the top level
// in use and is handed down one cell per level as the search descends. After the accept
// cycle each forward step along a level runs a link read, a key read and a compare; a
// level closes once its link is read when that link is null, or at the compare when it
// meets a key not below the request key. After the walk: search, update, a refused insert
// and a delete of a missing key decide and respond; a fresh insert decides, draws its
// height from the LCG (one step per cycle), allocates, links all levels in parallel and
// responds; a delete decides, unlinks all levels in parallel, tests the top level, drops
// each empty top level in turn and responds. A request of func 3 is accepted and answered
// with "not found". The respond cycle repeats while an earlier response is still waiting.
// The header links are flip-flops cleared by reset, so no clearing pass is needed after
// reset. The response sits in an output register, so the next request is accepted while
// an earlier response still waits to be taken.
`include "assert_macros.svh"
module skip_list_key_value_store_core #(
    parameter int NODE_COUNT = skl_pkg::NODE_COUNT_DEF,
    parameter int MAX_LEVELS = skl_pkg::MAX_LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    skl_req_if.sink     req,
    skl_rsp_if.source   rsp
);
    import skl_pkg::*;

    localparam int LINK_W = $clog2(NODE_COUNT + 1);
    localparam int CNT_W  = LINK_W;
    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
    localparam int LIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODE_COUNT);

    // Control state
    fsm_state_t        state_reg, state_next;
    logic [LVL_W-1:0]  act_reg, act_next;
    logic [CNT_W-1:0]  stored_reg, stored_next;
    logic [KEY_W-1:0]  seed_reg, seed_next;
    logic              out_valid_reg, out_valid_next;

    // Request payload and walk datapath
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  value_reg, value_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] nx_reg, nx_next;
    logic              hit_reg, hit_next;
    logic [NODE_W-1:0] t_reg, t_next;
    logic [KEY_W-1:0]  rv_reg, rv_next;
    logic [LVL_W-1:0]  h_reg, h_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Response register
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_found_reg;
    logic [KEY_W-1:0]    out_value_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_load;

    // Level cell row
    cell_cmd_t         cmd;
    logic [MAX_LEVELS-1:0] tok;
    logic [LINK_W-1:0] head_link [MAX_LEVELS];
    logic [LINK_W-1:0] rd_link   [MAX_LEVELS];
    logic [LINK_W-1:0] hdr_sel;
    logic [LINK_W-1:0] rd_sel;
    logic [LINK_W-1:0] nx_w;
    logic [LINK_W-1:0] cap_nx;
    logic [NODE_W-1:0] cell_raddr;
    logic [LVL_W-1:0]  act_m1;
    logic [LINK_W-1:0] top_head;

    // Node store
    store_ctl_t        ctl;
    logic [NODE_W-1:0] key_raddr;
    logic [NODE_W-1:0] store_waddr;
    logic [KEY_W-1:0]  key_rd;
    logic [KEY_W-1:0]  val_rd;
    logic [NODE_W-1:0] alloc_node;
    logic [CNT_W-1:0]  free_count;
    logic [KEY_W-1:0]  seed_step;

    assign act_m1     = act_reg - LVL_W'(1);
    assign top_head   = head_link[act_m1[LIDX_W-1:0]];
    assign cell_raddr = (state_reg == ST_UNLINK_RD) ? t_reg : cur_reg[NODE_W-1:0];
    assign seed_step  = seed_reg * LCG_MUL + LCG_INC;

    // Pick the header link and the read link of the level that holds the token
    always_comb
    begin
        hdr_sel = '0;
        rd_sel  = '0;
        for (int lvl = 0; lvl < MAX_LEVELS; lvl++)
        begin
            hdr_sel = hdr_sel | ({LINK_W{tok[lvl]}} & head_link[lvl]);
            rd_sel  = rd_sel  | ({LINK_W{tok[lvl]}} & rd_link[lvl]);
        end
    end

    assign nx_w = (cur_reg == LINK_NULL) ? hdr_sel : rd_sel;

    genvar l;
    generate
        for (l = 0; l < MAX_LEVELS; l++)
        begin : g_cell
            logic tok_above;
            if (l == MAX_LEVELS - 1)
            begin : g_top
                assign tok_above = 1'b0;
            end
            else
            begin : g_mid
                assign tok_above = tok[l+1];
            end

            skl_level_cell #(
                .NODE_COUNT (NODE_COUNT),
                .LEVEL      (l),
                .LINK_W     (LINK_W),
                .NODE_W     (NODE_W),
                .LVL_W      (LVL_W),
                .LIDX_W     (LIDX_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .start_lvl  (act_m1[LIDX_W-1:0]),
                .tok_above  (tok_above),
                .cur        (cur_reg),
                .nx         (cap_nx),
                .rd_addr    (cell_raddr),
                .node       (t_reg),
                .height     (h_reg),
                .tok        (tok[l]),
                .head_link  (head_link[l]),
                .rd_link    (rd_link[l])
            );
        end
    endgenerate

    skl_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .NODE_W     (NODE_W),
        .CNT_W      (CNT_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .raddr      (key_raddr),
        .waddr      (store_waddr),
        .wkey       (key_reg),
        .wval       (value_reg),
        .push_node  (t_reg),
        .key_rd     (key_rd),
        .val_rd     (val_rd),
        .alloc_node (alloc_node),
        .free_count (free_count)
    );

    // Sequencer: walk down the levels, then update, insert or unlink
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        stored_next = stored_reg;
        seed_next   = seed_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        cur_next    = cur_reg;
        nx_next     = nx_reg;
        hit_next    = hit_reg;
        t_next      = t_reg;
        rv_next     = rv_reg;
        h_next      = h_reg;
        status_next = status_reg;
        cmd         = '0;
        ctl         = '0;
        cap_nx      = nx_reg;
        key_raddr   = nx_w[NODE_W-1:0];
        store_waddr = t_reg;
        out_load    = 1'b0;
        req.ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    func_next   = req.func;
                    key_next    = req.key;
                    value_next  = req.value;
                    hit_next    = 1'b0;
                    status_next = STATUS_MISSING;
                    case (req.func)
                        FUNC_INSERT, FUNC_SEARCH, FUNC_DELETE:
                        begin
                            cmd.start  = 1'b1;
                            cur_next   = LINK_NULL;
                            state_next = ST_WLINK;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_WLINK:
            begin
                // link read of cur issues in this cycle
                state_next = ST_WNODE;
            end

            ST_WNODE:
            begin
                if (nx_w >= LINK_NULL)
                begin
                    cmd.cap = 1'b1;
                    cap_nx  = nx_w;
                    state_next = tok[0] ? ST_DECIDE : ST_WLINK;
                end
                else
                begin
                    nx_next    = nx_w;
                    state_next = ST_WKEY;
                end
            end

            ST_WKEY:
            begin
                if ($signed(key_rd) >= $signed(key_reg))
                begin
                    cmd.cap = 1'b1;
                    if (tok[0])
                    begin
                        hit_next   = (key_rd == key_reg);
                        t_next     = nx_reg[NODE_W-1:0];
                        rv_next    = val_rd;
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_WLINK;
                    end
                end
                else
                begin
                    cur_next   = nx_reg;
                    state_next = ST_WLINK;
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_FINISH;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            ctl.val_we  = 1'b1;
                            status_next = STATUS_OK;
                        end
                        else if (free_count == '0)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            h_next     = LVL_W'(1);
                            state_next = ST_HEIGHT;
                        end
                    end
                    FUNC_SEARCH:
                    begin
                        if (hit_reg)
                        begin
                            status_next = STATUS_OK;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            state_next = ST_UNLINK_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_HEIGHT:
            begin
                // one LCG step per cycle; grow while the tested bit is set
                if (h_reg < LVL_W'(MAX_LEVELS))
                begin
                    seed_next = seed_step;
                    if (seed_step[HEIGHT_BIT])
                    begin
                        h_next = h_reg + LVL_W'(1);
                    end
                    else
                    begin
                        state_next = ST_ALLOC;
                    end
                end
                else
                begin
                    state_next = ST_ALLOC;
                end
            end

            ST_ALLOC:
            begin
                ctl.pop     = 1'b1;
                ctl.key_we  = 1'b1;
                ctl.val_we  = 1'b1;
                store_waddr = alloc_node;
                t_next      = alloc_node;
                if (h_reg > act_reg)
                begin
                    act_next = h_reg;
                end
                stored_next = stored_reg + CNT_W'(1);
                status_next = STATUS_OK;
                state_next  = ST_LINK_SUCC;
            end

            ST_LINK_SUCC:
            begin
                cmd.link_succ = 1'b1;
                state_next    = ST_LINK_PRED;
            end

            ST_LINK_PRED:
            begin
                cmd.link_pred = 1'b1;
                state_next    = ST_FINISH;
            end

            ST_UNLINK_RD:
            begin
                // links of the victim are read in every cell at once
                state_next = ST_UNLINK_WR;
            end

            ST_UNLINK_WR:
            begin
                cmd.unlink = 1'b1;
                ctl.push   = 1'b1;
                if (stored_reg != '0)
                begin
                    stored_next = stored_reg - CNT_W'(1);
                end
                status_next = STATUS_OK;
                state_next  = ST_LOWER;
            end

            ST_LOWER:
            begin
                if ((act_reg > LVL_W'(1)) && (top_head >= LINK_NULL))
                begin
                    act_next = act_m1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the response until taken; a new one may replace it in the cycle it leaves
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= LVL_W'(1);
            stored_reg    <= '0;
            seed_reg      <= SEED_INIT;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            stored_reg    <= stored_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        cur_reg    <= cur_next;
        nx_reg     <= nx_next;
        t_reg      <= t_next;
        rv_reg     <= rv_next;
        h_reg      <= h_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= hit_reg;
            out_value_reg  <= ((func_reg == FUNC_SEARCH) && hit_reg) ? rv_reg : '0;
            out_count_reg  <= stored_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;

    // At most one level cell holds the walk token
    `SKL_ASSERT_ALWAYS(a_tok_single, clk, rst_n, $onehot0(tok))
    // Every node is either free or holds a key
    `SKL_ASSERT_ALWAYS(a_pool_balance, clk, rst_n,
        (CNT_W+1)'(free_count) + (CNT_W+1)'(stored_reg) == (CNT_W+1)'(NODE_COUNT))
    // Active level count stays within the cell row
    `SKL_ASSERT_ALWAYS(a_act_range, clk, rst_n,
        (act_reg >= LVL_W'(1)) && (act_reg <= LVL_W'(MAX_LEVELS)))
    // A walk level only closes while the token is in the row
    `SKL_ASSERT_IMPL(a_cap_tok, clk, rst_n, cmd.cap, tok != '0)

endmodule
